### hw/rtl/slrr_pkg.sv
// Shared types, codes and constants for the serial display report receiver.
package slrr_pkg;

  // Default frame buffer depth in bytes
  localparam int BUFFER_BYTES_DEF = 32;

  // Width used to compare the fill count with the length byte plus overhead
  localparam int CNT_W = 9;

  // Frame positions that the decoder looks at
  localparam int VIEW_LO = 2;
  localparam int VIEW_HI = 12;

  // Frame layout constants
  localparam logic [7:0] FUNC_KEY     = 8'h83;
  localparam logic [7:0] FUNC_REG_RD  = 8'h81;
  localparam logic [7:0] REG_RTC      = 8'h20;
  localparam logic [7:0] HOUR_OFFSET  = 8'd12;
  localparam logic [7:0] LEN_OVERHEAD = 8'd3;
  localparam logic [7:0] NIB_HI_MASK  = 8'hf0;
  localparam logic [7:0] NIB_LO_MASK  = 8'h0f;

  // Configuration reset values
  localparam logic [7:0]  HEADER_FIRST_RST  = 8'h5a;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'ha5;
  localparam logic [15:0] SLEEP_TIMEOUT_RST = 16'd0;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_SLEEP_TIMEOUT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_WAKE = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_KEY   = 2'd1,
    EV_CLOCK = 2'd2,
    EV_OTHER = 2'd3
  } event_t;

  // Input item
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } req_item_t;

  // Result item
  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] key_address;
    logic [15:0] key_data;
    logic [31:0] value_word;
    logic [7:0]  clock_year;
    logic [7:0]  clock_month;
    logic [7:0]  clock_day;
    logic [7:0]  clock_hour;
    logic [7:0]  clock_minute;
    logic [7:0]  clock_second;
    logic        sleep_request;
  } rsp_item_t;

  // Control from the item stage to the frame buffer
  typedef struct packed {
    logic       byte_we;
    logic       consume;
    logic [7:0] rx_byte;
  } frame_ctl_t;

  // Frame bytes at fixed positions, as seen by the decoder
  typedef logic [VIEW_HI:VIEW_LO][7:0] frame_view_t;

endpackage

### hw/rtl/slrr_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface slrr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/slrr_frame.sv
// Frame buffer: header detection, byte store and write index.
module slrr_frame #(
  parameter int BUFFER_BYTES = slrr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  slrr_pkg::frame_ctl_t   ctl,
  input  logic [7:0]             header_first,
  input  logic [7:0]             header_second,
  output slrr_pkg::frame_view_t  view,
  output logic                   complete
);
  localparam int IDX_W = $clog2(BUFFER_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_BYTES - 1);

  logic [BUFFER_BYTES-1:0][7:0] store;
  logic [IDX_W-1:0]             wr_idx;
  logic [IDX_W-1:0]             wr_idx_next;
  logic [IDX_W-1:0]             wr_at;
  logic                         armed;
  logic                         armed_next;
  logic                         restart;

  // Arm on the first header byte, restart the frame when the second follows
  always_comb begin
    restart    = 1'b0;
    armed_next = armed;
    if (ctl.rx_byte == header_first) begin
      armed_next = 1'b1;
    end else if (armed) begin
      restart    = (ctl.rx_byte == header_second);
      armed_next = 1'b0;
    end
    wr_at       = restart ? IDX_W'(1) : wr_idx;
    wr_idx_next = (wr_at == IDX_LAST) ? '0 : wr_at + IDX_W'(1);
  end

  // Store bytes, wrap the index at the buffer end, clear it on consume
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      armed  <= 1'b0;
      store  <= '0;
    end else if (ctl.consume) begin
      wr_idx <= '0;
    end else if (ctl.byte_we) begin
      armed  <= armed_next;
      wr_idx <= wr_idx_next;
      if (restart) begin
        store[0] <= header_first;
      end
      store[wr_at] <= ctl.rx_byte;
    end
  end

  // Expose the fixed positions that the decoder reads
  for (genvar i = slrr_pkg::VIEW_LO; i <= slrr_pkg::VIEW_HI; i++) begin : g_view
    assign view[i] = store[i];
  end

  // A frame is complete once the fill count covers length byte plus overhead
  assign complete = slrr_pkg::CNT_W'(wr_idx) >=
                    (slrr_pkg::CNT_W'(view[2]) + slrr_pkg::CNT_W'(slrr_pkg::LEN_OVERHEAD));

endmodule

### hw/rtl/slrr_decode.sv
// Frame decoder: key reports and clock readings from a complete frame.
module slrr_decode (
  input  slrr_pkg::frame_view_t view,
  output slrr_pkg::rsp_item_t   result
);
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = (b & slrr_pkg::NIB_HI_MASK) >> 4;
    lo = b & slrr_pkg::NIB_LO_MASK;
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // Pick the report by function code; other fields stay zero
  always_comb begin
    result = '0;
    if (view[3] == slrr_pkg::FUNC_KEY) begin
      result.event_kind  = slrr_pkg::EV_KEY;
      result.key_address = {view[4], view[5]};
      result.key_data    = {view[7], view[8]};
      result.value_word  = {view[7], view[8], view[9], view[10]};
    end else if (view[3] == slrr_pkg::FUNC_REG_RD && view[4] == slrr_pkg::REG_RTC) begin
      result.event_kind   = slrr_pkg::EV_CLOCK;
      result.clock_year   = bcd_value(view[6]);
      result.clock_month  = bcd_value(view[7]);
      result.clock_day    = bcd_value(view[8]);
      result.clock_hour   = bcd_value(view[10]) - slrr_pkg::HOUR_OFFSET;
      result.clock_minute = bcd_value(view[11]);
      result.clock_second = bcd_value(view[12]);
    end else begin
      result.event_kind = slrr_pkg::EV_OTHER;
    end
  end

endmodule

### hw/rtl/serial_lcd_report_receiver.sv
// Top level: item stage, idle sleep timer, configuration and result register.
// One item per clock while results are taken: an item is captured in the input
// register, handled once the output register is free or being emptied (frame
// buffer update, frame decode and sleep timer all in one pass) and its result
// lands in the output register, where it waits until it is taken.
// While a result waits, the input register still takes one more item; the
// input stalls only when that item and a result not yet taken downstream are
// both held. The frame buffer sits in flip-flops that reset clears, so the
// block takes items right after reset.
module serial_lcd_report_receiver #(
  parameter int BUFFER_BYTES = slrr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  slrr_chan_if.sink                           req,
  slrr_chan_if.source                         rsp,
  input  logic                                cfg_we,
  input  logic [slrr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [slrr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  logic                 in_valid;
  slrr_pkg::req_item_t  in_item;
  logic                 go;

  logic [7:0]           header_first;
  logic [7:0]           header_second;
  logic [15:0]          sleep_timeout_ticks;

  logic [15:0]          idle_count;
  logic [15:0]          idle_count_next;
  logic                 asleep;
  logic                 asleep_next;
  logic                 sleep_fire;
  logic [15:0]          idle_base;
  logic [15:0]          idle_inc;

  slrr_pkg::frame_ctl_t  frame_ctl;
  slrr_pkg::frame_view_t view;
  logic                  complete;
  slrr_pkg::rsp_item_t   decoded;
  slrr_pkg::rsp_item_t   rsp_next;
  logic                  is_byte;
  logic                  is_tick;
  logic                  is_wake;

  // Handle the held item when the result register can take its result
  assign go        = in_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !in_valid || go;

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.payload;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first        <= slrr_pkg::HEADER_FIRST_RST;
      header_second       <= slrr_pkg::HEADER_SECOND_RST;
      sleep_timeout_ticks <= slrr_pkg::SLEEP_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slrr_pkg::CFG_HEADER_FIRST:  header_first        <= cfg_data[7:0];
        slrr_pkg::CFG_HEADER_SECOND: header_second       <= cfg_data[7:0];
        slrr_pkg::CFG_SLEEP_TIMEOUT: sleep_timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Decode the item kind
  always_comb begin
    is_byte = 1'b0;
    is_tick = 1'b0;
    is_wake = 1'b0;
    unique case (slrr_pkg::req_kind_t'(in_item.req_type))
      slrr_pkg::REQ_BYTE: is_byte = 1'b1;
      slrr_pkg::REQ_TICK: is_tick = 1'b1;
      slrr_pkg::REQ_WAKE: is_wake = 1'b1;
      default: ;
    endcase
  end

  assign frame_ctl.byte_we = go && is_byte;
  assign frame_ctl.consume = go && is_tick && complete;
  assign frame_ctl.rx_byte = in_item.rx_byte;

  slrr_frame #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .ctl           (frame_ctl),
    .header_first  (header_first),
    .header_second (header_second),
    .view          (view),
    .complete      (complete)
  );

  slrr_decode u_decode (
    .view   (view),
    .result (decoded)
  );

  // Advance the idle timer on a tick, after any frame consume; a wake item ends sleep
  always_comb begin
    idle_base       = (is_tick && complete) ? '0 : idle_count;
    idle_inc        = idle_base + 16'd1;
    idle_count_next = idle_count;
    asleep_next     = asleep;
    sleep_fire      = 1'b0;
    if (is_tick) begin
      idle_count_next = idle_base;
      if (sleep_timeout_ticks != '0 && !asleep) begin
        if (idle_inc >= sleep_timeout_ticks) begin
          idle_count_next = '0;
          asleep_next     = 1'b1;
          sleep_fire      = 1'b1;
        end else begin
          idle_count_next = idle_inc;
        end
      end
    end else if (is_wake) begin
      asleep_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count <= '0;
      asleep     <= 1'b0;
    end else if (go) begin
      idle_count <= idle_count_next;
      asleep     <= asleep_next;
    end
  end

  // Build the result: a report only for a tick that completes a frame, plus the sleep request flag
  always_comb begin
    rsp_next = '0;
    if (is_tick && complete) begin
      rsp_next = decoded;
    end
    rsp_next.sleep_request = sleep_fire;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.payload <= rsp_next;
    end
  end

  // A timeout puts the block to sleep with the idle count cleared
  a_sleep_enter: assert property (@(posedge clk) disable iff (rst)
    (go && sleep_fire) |=> (asleep && idle_count == '0))
    else $error("sleep request without entering sleep");

  // The idle count stays cleared while asleep
  a_idle_while_asleep: assert property (@(posedge clk) disable iff (rst)
    asleep |-> (idle_count == '0))
    else $error("idle count moved while asleep");

  // Key fields are only set on a key report
  a_key_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.event_kind != slrr_pkg::EV_KEY) |->
      (rsp.payload.key_address == '0 && rsp.payload.key_data == '0 &&
       rsp.payload.value_word == '0))
    else $error("key fields set outside a key report");

endmodule

### test/serial_lcd_report_check.sv
// Checker for the serial display report receiver: predicts each result and compares it.
module serial_lcd_report_check
  import slrr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_ready,
  input  req_item_t              req_item,
  input  logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  rsp_item_t              rsp_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     pending
);

  localparam int FRAME_BYTES = BUFFER_BYTES_DEF;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  // Predicted copy of the receiver state and its registers
  logic [7:0]  frame_mem [FRAME_BYTES];
  int          fill_pos;
  bit          armed;
  logic [15:0] idle_ticks;
  bit          dozing;
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  logic [15:0] sleep_limit;

  rsp_item_t   expected_reports [$];
  int          mismatch_tally = 0;
  int          reports_seen = 0;
  int          waiting = 0;

  assign mismatch_count = mismatch_tally;
  assign pending        = waiting;

  function automatic logic [7:0] bcd_to_bin(logic [7:0] v);
    logic [7:0] tens;
    tens = (v & NIB_HI_MASK) >> 4;
    return tens * 8'd10 + (v & NIB_LO_MASK);
  endfunction

  // Advance the predicted state by one item and return the report it causes
  function automatic rsp_item_t predict_report(req_item_t it);
    rsp_item_t r;
    logic [7:0] b;
    r = '0;
    b = it.rx_byte;
    case (it.req_type)
      REQ_BYTE: begin
        if (b == hdr_first) begin
          armed = 1'b1;
        end else if (armed) begin
          // header pair seen: restart the frame behind the first header byte
          if (b == hdr_second) begin
            fill_pos     = 1;
            frame_mem[0] = hdr_first;
          end
          armed = 1'b0;
        end
        frame_mem[POS_W'(fill_pos)] = b;
        fill_pos++;
        if (fill_pos >= FRAME_BYTES) fill_pos = 0;
      end
      REQ_TICK: begin
        // decode and drop a complete frame
        if (fill_pos >= int'(frame_mem[2]) + int'(LEN_OVERHEAD)) begin
          if (frame_mem[3] == FUNC_KEY) begin
            r.event_kind  = EV_KEY;
            r.key_address = {frame_mem[4], frame_mem[5]};
            r.key_data    = {frame_mem[7], frame_mem[8]};
            r.value_word  = {frame_mem[7], frame_mem[8], frame_mem[9], frame_mem[10]};
          end else if (frame_mem[3] == FUNC_REG_RD && frame_mem[4] == REG_RTC) begin
            r.event_kind   = EV_CLOCK;
            r.clock_year   = bcd_to_bin(frame_mem[6]);
            r.clock_month  = bcd_to_bin(frame_mem[7]);
            r.clock_day    = bcd_to_bin(frame_mem[8]);
            r.clock_hour   = bcd_to_bin(frame_mem[10]) - HOUR_OFFSET;
            r.clock_minute = bcd_to_bin(frame_mem[11]);
            r.clock_second = bcd_to_bin(frame_mem[12]);
          end else begin
            r.event_kind = EV_OTHER;
          end
          fill_pos   = 0;
          idle_ticks = '0;
        end
        // count idle ticks toward sleep while awake
        if (sleep_limit != 16'd0 && !dozing) begin
          idle_ticks++;
          if (idle_ticks >= sleep_limit) begin
            idle_ticks      = '0;
            dozing          = 1'b1;
            r.sleep_request = 1'b1;
          end
        end
      end
      REQ_WAKE: dozing = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    $display("report %0d: %s", reports_seen, msg);
    mismatch_tally++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Track registers, queue predictions and compare delivered reports
  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      foreach (frame_mem[i]) frame_mem[i] = '0;
      fill_pos    = 0;
      armed       = 1'b0;
      idle_ticks  = '0;
      dozing      = 1'b0;
      hdr_first   = HEADER_FIRST_RST;
      hdr_second  = HEADER_SECOND_RST;
      sleep_limit = SLEEP_TIMEOUT_RST;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER_FIRST:  hdr_first   = cfg_data[7:0];
          CFG_HEADER_SECOND: hdr_second  = cfg_data[7:0];
          CFG_SLEEP_TIMEOUT: sleep_limit = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && req_ready)
        expected_reports.push_back(predict_report(req_item));
      if (rsp_valid && rsp_ready) begin
        if (expected_reports.size() == 0) begin
          log_mismatch("report with no item pending");
        end else begin
          want = expected_reports.pop_front();
          check_field("event_kind", 32'(rsp_item.event_kind), 32'(want.event_kind));
          check_field("key_address", 32'(rsp_item.key_address), 32'(want.key_address));
          check_field("key_data", 32'(rsp_item.key_data), 32'(want.key_data));
          check_field("value_word", rsp_item.value_word, want.value_word);
          check_field("clock_year", 32'(rsp_item.clock_year), 32'(want.clock_year));
          check_field("clock_month", 32'(rsp_item.clock_month), 32'(want.clock_month));
          check_field("clock_day", 32'(rsp_item.clock_day), 32'(want.clock_day));
          check_field("clock_hour", 32'(rsp_item.clock_hour), 32'(want.clock_hour));
          check_field("clock_minute", 32'(rsp_item.clock_minute),
                      32'(want.clock_minute));
          check_field("clock_second", 32'(rsp_item.clock_second),
                      32'(want.clock_second));
          check_field("sleep_request", 32'(rsp_item.sleep_request),
                      32'(want.sleep_request));
        end
        reports_seen++;
      end
    end
    waiting = expected_reports.size();
  end

endmodule

### test/serial_lcd_report_receiver_test.sv
// Testbench top for the serial display report receiver: stimulus, backpressure and verdict.
module serial_lcd_report_receiver_test;
  import slrr_pkg::*;

  localparam logic [1:0] REQ_UNUSED       = 2'd3;
  localparam int         LIMIT_CYCLES     = 400000;
  localparam int         LONG_HOLD_CYCLES = 80;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  int                     mismatches;
  int                     pending;
  int                     items_sent     = 0;
  int                     long_hold_asks = 0;
  bit                     quiet_send     = 1'b0;
  logic [7:0]             cur_first      = HEADER_FIRST_RST;
  logic [7:0]             cur_second     = HEADER_SECOND_RST;

  slrr_chan_if #(.payload_t(req_item_t)) req_ch ();
  slrr_chan_if #(.payload_t(rsp_item_t)) rsp_ch ();

  serial_lcd_report_receiver u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  serial_lcd_report_check u_check (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_ch.valid),
    .req_ready      (req_ch.ready),
    .req_item       (req_ch.payload),
    .rsp_valid      (rsp_ch.valid),
    .rsp_ready      (rsp_ch.ready),
    .rsp_item       (rsp_ch.payload),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .pending        (pending)
  );

  initial forever #4 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #(LIMIT_CYCLES * 8);
    $display("serial_lcd_report_receiver: mismatch");
    $finish;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_req(logic [1:0] kind, logic [7:0] value);
    req_item_t it;
    int gap;
    it.req_type = kind;
    it.rx_byte  = value;
    gap = idle_len(quiet_send);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.payload <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding report
  task automatic wait_reports_done();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] hf, logic [7:0] hs, logic [15:0] timeout);
    wait_reports_done();
    write_reg(CFG_HEADER_FIRST, 16'(hf));
    write_reg(CFG_HEADER_SECOND, 16'(hs));
    write_reg(CFG_SLEEP_TIMEOUT, timeout);
    cur_first  = hf;
    cur_second = hs;
  endtask

  // Well-formed frame with random function, length and content
  task automatic send_frame();
    int body;
    int len;
    logic [7:0] fn;
    logic [7:0] b;
    body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 28) : $urandom_range(8, 12);
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, body);
    case ($urandom_range(0, 3))
      0:       fn = FUNC_KEY;
      1, 2:    fn = FUNC_REG_RD;
      default: fn = 8'($urandom);
    endcase
    send_req(REQ_BYTE, cur_first);
    send_req(REQ_BYTE, cur_second);
    send_req(REQ_BYTE, 8'(len));
    for (int i = 0; i < body; i++) begin
      if (i == 0) b = fn;
      else if (i == 1 && fn == FUNC_REG_RD && $urandom_range(0, 3) != 0) b = REG_RTC;
      else if ($urandom_range(0, 1) == 0)
        b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      else b = 8'($urandom);
      send_req(REQ_BYTE, b);
      // occasional tick in the middle of a frame
      if ($urandom_range(0, 24) == 0) send_req(REQ_TICK, 8'($urandom));
    end
    repeat (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2))
      send_req(REQ_TICK, 8'($urandom));
  endtask

  // Mostly frames, the rest noise and broken sequences
  task automatic play_random(int upto);
    int r;
    while (items_sent < upto) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame();
      end else if (r < 78) begin
        repeat ($urandom_range(1, 6)) send_req(REQ_BYTE, 8'($urandom));
      end else if (r < 86) begin
        send_req(REQ_TICK, 8'($urandom));
      end else if (r < 91) begin
        send_req(REQ_WAKE, 8'($urandom));
      end else if (r < 94) begin
        send_req(REQ_UNUSED, 8'($urandom));
      end else if (r < 97) begin
        // first header byte not followed by the second
        send_req(REQ_BYTE, cur_first);
        send_req(REQ_BYTE, 8'($urandom));
        send_req(REQ_TICK, 8'($urandom));
      end else begin
        // long run that can wrap the frame buffer
        repeat ($urandom_range(20, 40)) send_req(REQ_BYTE, 8'($urandom));
        send_req(REQ_TICK, 8'($urandom));
      end
    end
  endtask

  // Report receiver: random stalls, quiet stretches and requested long holds
  initial begin
    int hold;
    int served;
    int cyc;
    bit calm;
    hold   = 0;
    served = 0;
    cyc    = 0;
    calm   = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_asks > served) begin
        served++;
        hold = LONG_HOLD_CYCLES;
      end
      if (cyc % 200 == 0) calm = ($urandom_range(0, 3) == 0);
      cyc++;
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
        hold = idle_len(calm);
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] key_frame [11] = '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h08, FUNC_KEY,
                                   8'h12, 8'h34, 8'h00, 8'hff, 8'h00, 8'hab, 8'hcd};
    logic [7:0] clock_frame [13] = '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h0a, FUNC_REG_RD,
                                     REG_RTC, 8'h00, 8'h99, 8'h12, 8'h31, 8'h00, 8'h00,
                                     8'h59, 8'h59};
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty tick, unused kind, wake while awake, key and clock frames
    set_config(HEADER_FIRST_RST, HEADER_SECOND_RST, SLEEP_TIMEOUT_RST);
    send_req(REQ_TICK, 8'h00);
    send_req(REQ_UNUSED, 8'hff);
    send_req(REQ_WAKE, 8'h00);
    foreach (key_frame[i]) send_req(REQ_BYTE, key_frame[i]);
    send_req(REQ_TICK, 8'h00);
    // hour byte of zero wraps below zero after the offset
    foreach (clock_frame[i]) send_req(REQ_BYTE, clock_frame[i]);
    send_req(REQ_TICK, 8'hff);

    play_random(180);

    // Short timeout; fill the block behind a long receiver hold
    set_config(8'($urandom), 8'($urandom), 16'($urandom_range(2, 6)));
    quiet_send = 1'b1;
    long_hold_asks++;
    play_random(items_sent + 40);
    quiet_send = 1'b0;
    play_random(340);

    // Both headers equal, largest timeout
    set_config(8'hff, 8'hff, 16'hffff);
    play_random(480);

    // Header extremes, timeout of one, sender with no gaps
    set_config(8'h00, 8'hff, 16'd1);
    quiet_send = 1'b1;
    play_random(600);
    quiet_send = 1'b0;

    // Lower the timeout below the idle count already reached
    set_config(8'($urandom), 8'($urandom), 16'd300);
    send_req(REQ_WAKE, 8'($urandom));
    repeat (20) send_req(REQ_TICK, 8'($urandom));
    set_config(cur_first, cur_second, 16'd3);
    send_req(REQ_TICK, 8'($urandom));
    play_random(720);

    set_config(8'($urandom), 8'($urandom), 16'($urandom_range(0, 20)));
    long_hold_asks++;
    play_random(880);

    // Drain and give the verdict
    wait_reports_done();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("serial_lcd_report_receiver: match");
    end else begin
      $display("serial_lcd_report_receiver: mismatch");
    end
    $finish;
  end

endmodule

### serial_lcd_report_receiver.f
hw/rtl/slrr_pkg.sv
hw/rtl/slrr_chan_if.sv
hw/rtl/slrr_frame.sv
hw/rtl/slrr_decode.sv
hw/rtl/serial_lcd_report_receiver.sv
test/serial_lcd_report_check.sv
test/serial_lcd_report_receiver_test.sv
